// ----- src/can_hvac_signal_decoder_unit_assert.svh -----
// ----------------------------------------------------------------------------
// can_hvac_signal_decoder_unit_assert.svh
// Assertion macros shared by the HVAC signal decoder RTL.
// ----------------------------------------------------------------------------
`ifndef CAN_HVAC_SIGNAL_DECODER_UNIT_ASSERT_SVH
`define CAN_HVAC_SIGNAL_DECODER_UNIT_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define CSHD_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define CSHD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/cshd_pkg.sv -----
// ----------------------------------------------------------------------------
// cshd_pkg
// Types and constants of the CAN HVAC signal decoder.
// ----------------------------------------------------------------------------
package cshd_pkg;

	localparam int IdW      = 29;
	localparam int InDataW  = 88;
	localparam int OutDataW = 48;
	localparam int CfgIdxW  = 2;

	// register indexes on the configuration channel
	localparam logic [CfgIdxW-1:0] RegOatId      = 2'd0;
	localparam logic [CfgIdxW-1:0] RegSetpointId = 2'd1;
	localparam logic [CfgIdxW-1:0] RegFanId      = 2'd2;
	localparam logic [CfgIdxW-1:0] RegDimId      = 2'd3;

	localparam logic [IdW-1:0] OatIdRst      = 29'h3C4;
	localparam logic [IdW-1:0] SetpointIdRst = 29'h3C8;
	localparam logic [IdW-1:0] FanIdRst      = 29'h357;
	localparam logic [IdW-1:0] DimIdRst      = 29'h3B3;

	localparam logic signed [13:0] OatRst = 14'sd720;
	localparam logic [6:0] DriverRst      = 7'd72;
	localparam logic [6:0] PassengerRst   = 7'd70;
	localparam logic [2:0] FanRst         = 3'd3;
	localparam logic [2:0] DimRst         = 3'd6;
	localparam logic [2:0] DimMax         = 3'd6;

	// received frame, can_id in the lowest bits
	typedef struct packed {
		logic [7:0]     data7;
		logic [7:0]     data6;
		logic [7:0]     data3;
		logic [7:0]     data2;
		logic [7:0]     data1;
		logic [7:0]     data0;
		logic [3:0]     length_code;
		logic [IdW-1:0] can_id;
	} item_t;

	typedef struct packed {
		logic [IdW-1:0] oat;
		logic [IdW-1:0] setpoint;
		logic [IdW-1:0] fan;
		logic [IdW-1:0] dim;
	} frame_ids_t;

	typedef struct packed {
		logic [2:0]        dim;
		logic [2:0]        fan;
		logic [6:0]        pas_sp;
		logic              pas_blank;
		logic [6:0]        drv_sp;
		logic              drv_blank;
		logic signed [13:0] oat;
	} store_t;

	// result item, oat_tenths in the lowest bits
	typedef struct packed {
		logic       used;
		logic [7:0] duty;
		store_t     st;
	} result_t;

endpackage

// ----- src/cshd_decode.sv -----
// ----------------------------------------------------------------------------
// cshd_decode
// Identifier match, length check and signal decode for one frame; gives the
// next value of the held signals.
// ----------------------------------------------------------------------------
module cshd_decode (
	input  cshd_pkg::item_t      item,
	input  cshd_pkg::frame_ids_t ids,
	input  cshd_pkg::store_t     cur,
	output cshd_pkg::store_t     nxt,
	output logic                 used,
	output logic [7:0]           duty
);
	import cshd_pkg::*;

	function automatic logic [3:0] digit_of(input logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) ? b[3:0] : 4'd0;
	endfunction

	function automatic logic [6:0] two_digits(input logic [7:0] hi, input logic [7:0] lo);
		logic [3:0] dh;
		logic [3:0] dl;
		dh = digit_of(hi);
		dl = digit_of(lo);
		return {dh, 3'b000} + {2'b00, dh, 1'b0} + {3'b000, dl};
	endfunction

	function automatic logic [2:0] fan_ladder(input logic [7:0] b);
		if (b == 8'h00) return 3'd0;
		if (b <= 8'h20) return 3'd1;
		if (b <= 8'h40) return 3'd2;
		if (b <= 8'h60) return 3'd3;
		if (b <= 8'h80) return 3'd4;
		if (b <= 8'hA0) return 3'd5;
		if (b <= 8'hC0) return 3'd6;
		return 3'd7;
	endfunction

	function automatic logic [2:0] dim_ladder(input logic [7:0] b);
		if (b == 8'h00) return 3'd0;
		if (b <= 8'h2A) return 3'd1;
		if (b <= 8'h55) return 3'd2;
		if (b <= 8'h80) return 3'd3;
		if (b <= 8'hAA) return 3'd4;
		if (b <= 8'hD5) return 3'd5;
		return 3'd6;
	endfunction

	// level*255/6 truncated to 8 bits
	function automatic logic [7:0] duty_of(input logic [2:0] lvl);
		case (lvl)
			3'd0:    return 8'd0;
			3'd1:    return 8'd42;
			3'd2:    return 8'd85;
			3'd3:    return 8'd127;
			3'd4:    return 8'd170;
			3'd5:    return 8'd212;
			3'd6:    return 8'd255;
			default: return 8'd41;
		endcase
	endfunction

	logic [15:0]        raw;
	logic [19:0]        prod;
	logic signed [14:0] oat_wide;
	logic               len_ok4;
	logic               len_ok8;
	logic               drv_blank;
	logic               pas_blank;

	// raw*9/64 by shift and add
	assign raw      = {item.data6, item.data7};
	assign prod     = {1'b0, raw, 3'b000} + {4'b0000, raw};
	assign oat_wide = $signed({1'b0, prod[19:6]}) - 15'sd1984;

	assign len_ok4   = item.length_code >= 4'd4;
	assign len_ok8   = item.length_code >= 4'd8;
	assign drv_blank = (item.data0 == 8'h00) && (item.data1 == 8'h00);
	assign pas_blank = (item.data2 == 8'h00) && (item.data3 == 8'h00);

	always_comb begin
		nxt  = cur;
		used = 1'b0;
		if (item.can_id == ids.oat) begin
			if (len_ok8) begin
				nxt.oat = oat_wide[13:0];
				used    = 1'b1;
			end
		end else if (item.can_id == ids.setpoint) begin
			if (len_ok4) begin
				nxt.drv_blank = drv_blank;
				nxt.drv_sp    = drv_blank ? 7'd0 : two_digits(item.data0, item.data1);
				nxt.pas_blank = pas_blank;
				nxt.pas_sp    = pas_blank ? 7'd0 : two_digits(item.data2, item.data3);
				if (drv_blank) begin
					nxt.fan = 3'd0;
				end
				used = 1'b1;
			end
		end else if (item.can_id == ids.fan) begin
			if (len_ok4) begin
				nxt.fan = fan_ladder(item.data3);
				used    = 1'b1;
			end
		end else if (item.can_id == ids.dim) begin
			if (len_ok4) begin
				nxt.dim = dim_ladder(item.data3);
				used    = 1'b1;
			end
		end
	end

	assign duty = duty_of(nxt.dim);

endmodule

// ----- src/can_hvac_signal_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// can_hvac_signal_decoder_unit
// Decodes HVAC signals from received CAN frames and emits a snapshot of the
// held values for every frame.
// ----------------------------------------------------------------------------
//  channel   direction  transfer when          content
//  s_*       in         s_tvalid & s_tready    one received frame
//  m_*       out        m_tvalid & m_tready    snapshot of held values
//  cfg_*     in         cfg_valid & cfg_ready  frame identifier register write
//
//  One frame per cycle while the m_* side is not stalled; a frame passes the
//  input register, then is decoded into the result register, which raises
//  m_tvalid for the frame's snapshot.
//  Held values update as the frame moves into the result register.
//  arst_n restores the default identifiers and held values.
//  A stalled m_* side still lets one more frame in; cfg_ready is always high.
// ----------------------------------------------------------------------------
module can_hvac_signal_decoder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// can_id[28:0], length_code[32:29], data0, data1, data2, data3, data6,
	// data7 (8 bits each from bit 33 up), zero fill [87:81]
	input  logic [cshd_pkg::InDataW-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// oat_tenths[13:0], driver_blank[14], driver_setpoint[21:15],
	// passenger_blank[22], passenger_setpoint[29:23], fan_level[32:30],
	// dim_level[35:33], backlight_duty[43:36], frame_used[44], zero fill [47:45]
	output logic [cshd_pkg::OutDataW-1:0] m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cshd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [cshd_pkg::IdW-1:0]      cfg_data
);
	import cshd_pkg::*;

	frame_ids_t ids_q;
	item_t      item_s1;
	logic       valid_s1;
	store_t     store_q;
	store_t     store_nxt;
	logic       used_nxt;
	logic [7:0] duty_nxt;
	result_t    res_q;
	logic       m_valid_q;
	logic       advance;
	logic       s_xfer;
	logic       out_stall;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign s_xfer    = s_tvalid && s_tready;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = {{(OutDataW - $bits(result_t)){1'b0}}, res_q};
	assign out_stall = valid_s1 && m_valid_q && !m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ids_q.oat      <= OatIdRst;
			ids_q.setpoint <= SetpointIdRst;
			ids_q.fan      <= FanIdRst;
			ids_q.dim      <= DimIdRst;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				RegOatId:      ids_q.oat      <= cfg_data;
				RegSetpointId: ids_q.setpoint <= cfg_data;
				RegFanId:      ids_q.fan      <= cfg_data;
				RegDimId:      ids_q.dim      <= cfg_data;
				default:       ids_q          <= ids_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			item_s1 <= item_t'(s_tdata[$bits(item_t)-1:0]);
		end
	end

	cshd_decode u_decode (
		.item (item_s1),
		.ids  (ids_q),
		.cur  (store_q),
		.nxt  (store_nxt),
		.used (used_nxt),
		.duty (duty_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q.oat       <= OatRst;
			store_q.drv_blank <= 1'b0;
			store_q.drv_sp    <= DriverRst;
			store_q.pas_blank <= 1'b0;
			store_q.pas_sp    <= PassengerRst;
			store_q.fan       <= FanRst;
			store_q.dim       <= DimRst;
			m_valid_q         <= 1'b0;
		end else if (advance) begin
			store_q   <= store_nxt;
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.st   <= store_nxt;
			res_q.used <= used_nxt;
			res_q.duty <= duty_nxt;
		end
	end

	`include "can_hvac_signal_decoder_unit_assert.svh"

	`CSHD_ASSERT(a_dim_range, store_q.dim <= DimMax, "dim level out of range")
	`CSHD_ASSERT(a_blank_zero, !store_q.drv_blank || !(|store_q.drv_sp), "setpoint under blank")
	`CSHD_ASSERT(a_stall_cause, s_tready || out_stall, "input stalled without a full pipe")
	`CSHD_ASSERT_NEXT(a_hold_s1, out_stall, valid_s1 && m_valid_q, "frame lost in output stall")

endmodule
